[rtl/dtpcn_pkg.sv]
// ----------------------------------------------------------------------------
// dtpcn_pkg
// shared types and constants of the depth to point cloud block: register
// file layout, controller commands and datapath status
// ----------------------------------------------------------------------------
package dtpcn_pkg;

  localparam int DEPTH_W   = 16;
  localparam int NFRAC     = 14;            // normal fraction bits
  localparam int MAG_W     = NFRAC + 1;     // normal magnitude, 0 .. 1.0
  localparam int CENTER_W  = 26;
  localparam int FOCAL_W   = 32;
  localparam int DIM_W     = 10;
  localparam int POS_OUT_W = 9;
  localparam int VXY_W     = 28;
  localparam int VZ_W      = 17;
  localparam int NXY_W     = 16;
  localparam int SQ_W      = 2 * DEPTH_W;     // square of a depth difference
  localparam int Q_W       = SQ_W + 1;        // sum of two squares plus four
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 22;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MZ_W      = 2 * MUL_B_W;     // depth times offset
  localparam int BIT_W     = 4;
  localparam logic [MAG_W-1:0] NORM_ONE = MAG_W'(1) << NFRAC;
  localparam logic [BIT_W-1:0] BIT_TOP  = BIT_W'(NFRAC);

  // register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEPTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL      = 3'd7;

  // magnitude selects of the normal search
  localparam logic [1:0] MAG_X = 2'd0;
  localparam logic [1:0] MAG_Y = 2'd1;
  localparam logic [1:0] MAG_Z = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0]    frame_width;
    logic [DIM_W-1:0]    frame_height;
    logic [DEPTH_W-1:0]  min_depth;
    logic [DEPTH_W-1:0]  max_depth;
    logic [DEPTH_W-1:0]  edge_threshold;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [FOCAL_W-1:0]  inv_focal;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             rd0;
    logic             rd1;
    logic             rd2;
    logic             commit;
    logic             prep;
    logic             sq0;
    logic             sq1;
    logic             sq2;
    logic             t0;
    logic             t1;
    logic             t2;
    logic             t3;
    logic             p0;
    logic             p1;
    logic             p2;
    logic             p3;
    logic             emit;
    logic             sel_b;
    logic [1:0]       mag_sel;
    logic [BIT_W-1:0] bit_idx;
    logic             proj_y;
  } cmd_t;

  typedef struct packed {
    logic has_a;
    logic has_b;
    logic out_free;
  } sts_t;

endpackage

[rtl/dtpcn_ctrl.sv]
// ----------------------------------------------------------------------------
// dtpcn_ctrl
// sequencer: line store access, then per result the gating, squares,
// three normal magnitude searches, two projections and the output load
// ----------------------------------------------------------------------------
module dtpcn_ctrl
  import dtpcn_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [17:0] {
    S_IDLE = 18'b000000000000000001,
    S_RD0  = 18'b000000000000000010,
    S_RD1  = 18'b000000000000000100,
    S_RD2  = 18'b000000000000001000,
    S_WR   = 18'b000000000000010000,
    S_PREP = 18'b000000000000100000,
    S_SQ0  = 18'b000000000001000000,
    S_SQ1  = 18'b000000000010000000,
    S_SQ2  = 18'b000000000100000000,
    S_T0   = 18'b000000001000000000,
    S_T1   = 18'b000000010000000000,
    S_T2   = 18'b000000100000000000,
    S_T3   = 18'b000001000000000000,
    S_P0   = 18'b000010000000000000,
    S_P1   = 18'b000100000000000000,
    S_P2   = 18'b001000000000000000,
    S_P3   = 18'b010000000000000000,
    S_EMIT = 18'b100000000000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic             sel_b_r, sel_b_nxt;
  logic [1:0]       mag_sel_r, mag_sel_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic             proj_y_r, proj_y_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    sel_b_nxt   = sel_b_r;
    mag_sel_nxt = mag_sel_r;
    bit_nxt     = bit_r;
    proj_y_nxt  = proj_y_r;
    cmd         = '0;
    cmd.sel_b   = sel_b_r;
    cmd.mag_sel = mag_sel_r;
    cmd.bit_idx = bit_r;
    cmd.proj_y  = proj_y_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD0;
        end
      end
      S_RD0: begin
        cmd.rd0   = 1'b1;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.rd1   = 1'b1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.rd2   = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.commit = 1'b1;
        sel_b_nxt  = !sts.has_a;
        if (sts.has_a || sts.has_b) state_nxt = S_PREP;
        else state_nxt = S_IDLE;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_SQ0;
      end
      S_SQ0: begin
        cmd.sq0   = 1'b1;
        state_nxt = S_SQ1;
      end
      S_SQ1: begin
        cmd.sq1   = 1'b1;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        cmd.sq2     = 1'b1;
        mag_sel_nxt = MAG_X;
        bit_nxt     = BIT_TOP;
        state_nxt   = S_T0;
      end
      S_T0: begin
        cmd.t0    = 1'b1;
        state_nxt = S_T1;
      end
      S_T1: begin
        cmd.t1    = 1'b1;
        state_nxt = S_T2;
      end
      S_T2: begin
        cmd.t2    = 1'b1;
        state_nxt = S_T3;
      end
      S_T3: begin
        cmd.t3 = 1'b1;
        if (bit_r != '0) begin
          bit_nxt   = bit_r - BIT_W'(1);
          state_nxt = S_T0;
        end else if (mag_sel_r == MAG_Z) begin
          proj_y_nxt = 1'b0;
          state_nxt  = S_P0;
        end else begin
          mag_sel_nxt = mag_sel_r + 2'd1;
          bit_nxt     = BIT_TOP;
          state_nxt   = S_T0;
        end
      end
      S_P0: begin
        cmd.p0    = 1'b1;
        state_nxt = S_P1;
      end
      S_P1: begin
        cmd.p1    = 1'b1;
        state_nxt = S_P2;
      end
      S_P2: begin
        cmd.p2    = 1'b1;
        state_nxt = S_P3;
      end
      S_P3: begin
        cmd.p3 = 1'b1;
        if (!proj_y_r) begin
          proj_y_nxt = 1'b1;
          state_nxt  = S_P0;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (!sel_b_r && sts.has_b) begin
            sel_b_nxt = 1'b1;
            state_nxt = S_PREP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      sel_b_r   <= 1'b0;
      mag_sel_r <= MAG_X;
      bit_r     <= '0;
      proj_y_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sel_b_r   <= sel_b_nxt;
      mag_sel_r <= mag_sel_nxt;
      bit_r     <= bit_nxt;
      proj_y_r  <= proj_y_nxt;
    end
  end

endmodule

[rtl/dtpcn_dp.sv]
// ----------------------------------------------------------------------------
// dtpcn_dp
// datapath: raster counters, two line stores, neighbor gating, one shared
// 32x22 multiplier for squares, normal searches and projections, output beat
// ----------------------------------------------------------------------------
module dtpcn_dp
  import dtpcn_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic [DEPTH_W-1:0]      in_depth_mm,
  input  logic                    in_frame_start,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [POS_OUT_W-1:0]    out_pixel_row,
  output logic [POS_OUT_W-1:0]    out_pixel_col,
  output logic                    out_vertex_valid,
  output logic signed [VXY_W-1:0] out_vertex_x,
  output logic signed [VXY_W-1:0] out_vertex_y,
  output logic signed [VZ_W-1:0]  out_vertex_z,
  output logic signed [NXY_W-1:0] out_normal_x,
  output logic signed [NXY_W-1:0] out_normal_y,
  output logic [MAG_W-1:0]        out_normal_z,
  output logic                    out_frame_last
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = $clog2(MAX_HEIGHT + 1);
  localparam int PW = (WB > HB) ? WB : HB;
  localparam int MW = (PW + 16 > CENTER_W) ? PW + 16 : CENTER_W;
  localparam int SUM_W = MUL_P_W + MUL_B_W;

  function automatic logic [DEPTH_W-1:0] gate_nb(input logic [DEPTH_W-1:0] ctr,
                                                 input logic [DEPTH_W-1:0] nb,
                                                 input logic [DEPTH_W-1:0] thr);
    logic [DEPTH_W-1:0] d;
    d = (ctr > nb) ? ctr - nb : nb - ctr;
    return (d > thr) ? '0 : nb;
  endfunction

  // line stores
  logic [DEPTH_W-1:0] prev_mem [MAX_WIDTH];
  logic [DEPTH_W-1:0] older_mem [MAX_WIDTH];
  logic [DEPTH_W-1:0] prev_q_r, older_q_r;
  logic [AW-1:0]      rd_addr;

  // raster position
  logic [WB-1:0] col_r, w_eff, c0, c1, c_inc, col_nxt, cur_c_r;
  logic [HB-1:0] row_r, h_eff, r0, r1, r2, r_inc, row_nxt, cur_r_r;
  logic          has_a_r, has_b_r, last_r, inner_r;
  logic [DEPTH_W-1:0] depth_r, ctr_c_r, above_c_r, before_c_r, after_c_r, left_r;

  // result operands
  logic [DEPTH_W-1:0] ctr_r, ua_r, ub_r;
  logic               a_pos_r, b_pos_r, valid_r, olast_r;
  logic [HB-1:0]      orow_r;
  logic [WB-1:0]      ocol_r;
  logic [SQ_W-1:0]    ua2_r, ub2_r, t2_r;
  logic [Q_W-1:0]     q_r;
  logic [MAG_W-1:0]   lo_r, mx_r, my_r, mzn_r;
  logic [MZ_W-1:0]    mz_r;
  logic [MUL_P_W-1:0] plo_r, mul_p_r;
  logic               proj_neg_r;
  logic [VXY_W-1:0]   vx_r, vy_r;
  logic               out_valid_r;

  // multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;

  // per step combinational values
  logic [DEPTH_W-1:0] p_ctr, p_ab, p_be, p_bf, p_af, g_ab, g_be, g_bf, g_af;
  logic signed [DEPTH_W:0] da, db;
  logic [MAG_W-1:0]   cand, lo_new;
  logic               cand_ok;
  logic [MAG_W:0]     tval;
  logic [SQ_W-1:0]    m2;
  logic [65:0]        full, rhs;
  logic [PW-1:0]      pos;
  logic [CENTER_W-1:0] cval;
  logic [MW-1:0]      p16, cc, mag;
  logic               pneg;
  logic [SUM_W-1:0]   psum;
  logic [31:0]        rq, lim, rs;
  logic [VXY_W-1:0]   vres;

  // position of the arriving pixel and counters after it
  always_comb begin
    if (cfg.frame_width == '0) w_eff = WB'(1);
    else if (32'(cfg.frame_width) > MAX_WIDTH) w_eff = WB'(MAX_WIDTH);
    else w_eff = WB'(cfg.frame_width);
    if (cfg.frame_height == '0) h_eff = HB'(1);
    else if (32'(cfg.frame_height) > MAX_HEIGHT) h_eff = HB'(MAX_HEIGHT);
    else h_eff = HB'(cfg.frame_height);
    c0 = in_frame_start ? '0 : col_r;
    r0 = in_frame_start ? '0 : row_r;
    if (c0 >= w_eff) begin
      c1 = '0;
      r1 = r0 + HB'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2    = (r1 >= h_eff) ? '0 : r1;
    c_inc = c1 + WB'(1);
    r_inc = r2 + HB'(1);
    if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h_eff) ? '0 : r_inc;
    end else begin
      col_nxt = c_inc;
      row_nxt = r2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
    end else begin
      if (cmd.load) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (cmd.commit) left_r <= ctr_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      depth_r <= in_depth_mm;
      cur_c_r <= c1;
      cur_r_r <= r2;
      has_a_r <= (r2 != '0);
      has_b_r <= (r_inc == h_eff);
      last_r  <= (c_inc == w_eff);
      inner_r <= (r2 > HB'(1)) && (c1 != '0) && (c_inc < w_eff);
    end
    if (cmd.rd1) begin
      ctr_c_r    <= prev_q_r;
      above_c_r  <= older_q_r;
      before_c_r <= left_r;
    end
    if (cmd.rd2) after_c_r <= prev_q_r;
  end

  assign rd_addr = cmd.rd1 ? cur_c_r[AW-1:0] + AW'(1) : cur_c_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.rd0 || cmd.rd1) prev_q_r <= prev_mem[rd_addr];
    if (cmd.rd0) older_q_r <= older_mem[rd_addr];
    if (cmd.commit) begin
      prev_mem[cur_c_r[AW-1:0]]  <= depth_r;
      older_mem[cur_c_r[AW-1:0]] <= ctr_c_r;
    end
  end

  // neighbor gating and differences
  always_comb begin
    p_ctr = cmd.sel_b ? depth_r : ctr_c_r;
    p_ab  = (!cmd.sel_b && inner_r) ? above_c_r  : '0;
    p_be  = (!cmd.sel_b && inner_r) ? depth_r    : '0;
    p_bf  = (!cmd.sel_b && inner_r) ? before_c_r : '0;
    p_af  = (!cmd.sel_b && inner_r) ? after_c_r  : '0;
    g_ab  = gate_nb(p_ctr, p_ab, cfg.edge_threshold);
    g_be  = gate_nb(p_ctr, p_be, cfg.edge_threshold);
    g_bf  = gate_nb(p_ctr, p_bf, cfg.edge_threshold);
    g_af  = gate_nb(p_ctr, p_af, cfg.edge_threshold);
    da    = $signed({1'b0, g_be}) - $signed({1'b0, g_ab});
    db    = $signed({1'b0, g_af}) - $signed({1'b0, g_bf});
  end

  // normal search trial
  always_comb begin
    cand    = lo_r | (MAG_W'(1) << cmd.bit_idx);
    cand_ok = (cand <= NORM_ONE);
    tval    = {cand, 1'b0} - (MAG_W + 1)'(1);
    case (cmd.mag_sel)
      MAG_X:   m2 = ua2_r;
      MAG_Y:   m2 = ub2_r;
      default: m2 = SQ_W'(4);
    endcase
    full   = (66'(mul_p_r[47:0]) << 17) + 66'(plo_r[48:0]);
    rhs    = 66'(m2) << 30;
    lo_new = (cand_ok && (full <= rhs)) ? cand : lo_r;
  end

  // projection
  always_comb begin
    pos  = cmd.proj_y ? PW'(orow_r) : PW'(ocol_r);
    cval = cmd.proj_y ? cfg.center_y : cfg.center_x;
    p16  = MW'({pos, 16'h0000});
    cc   = MW'(cval);
    if (p16 >= cc) begin
      mag  = p16 - cc;
      pneg = 1'b0;
    end else begin
      mag  = cc - p16;
      pneg = 1'b1;
    end
    if (cmd.proj_y) pneg = !pneg;
    psum = {mul_p_r, {MUL_B_W{1'b0}}} + SUM_W'(plo_r) + (SUM_W'(1) << 43);
    rq   = psum[SUM_W-1:44];
    lim  = proj_neg_r ? (32'd1 << 27) : ((32'd1 << 27) - 32'd1);
    rs   = (rq > lim) ? lim : rq;
    vres = proj_neg_r ? VXY_W'(0) - rs[VXY_W-1:0] : rs[VXY_W-1:0];
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.sq0) begin
      mul_a = MUL_A_W'(ua_r);
      mul_b = MUL_B_W'(ua_r);
    end else if (cmd.sq1) begin
      mul_a = MUL_A_W'(ub_r);
      mul_b = MUL_B_W'(ub_r);
    end else if (cmd.t0) begin
      mul_a = MUL_A_W'(tval);
      mul_b = MUL_B_W'(tval);
    end else if (cmd.t1) begin
      mul_a = mul_p_r[MUL_A_W-1:0];
      mul_b = MUL_B_W'(q_r[16:0]);
    end else if (cmd.t2) begin
      mul_a = t2_r;
      mul_b = MUL_B_W'(q_r[Q_W-1:17]);
    end else if (cmd.p0) begin
      mul_a = MUL_A_W'(mag);
      mul_b = MUL_B_W'(ctr_r);
    end else if (cmd.p1) begin
      mul_a = cfg.inv_focal;
      mul_b = mul_p_r[MUL_B_W-1:0];
    end else if (cmd.p2) begin
      mul_a = cfg.inv_focal;
      mul_b = mz_r[MZ_W-1:MUL_B_W];
    end
  end

  always_ff @(posedge clk) begin
    mul_p_r <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    if (cmd.prep) begin
      ctr_r   <= p_ctr;
      valid_r <= (p_ctr != '0) && (p_ctr >= cfg.min_depth) && (p_ctr <= cfg.max_depth);
      ua_r    <= da[DEPTH_W] ? DEPTH_W'(-da) : da[DEPTH_W-1:0];
      ub_r    <= db[DEPTH_W] ? DEPTH_W'(-db) : db[DEPTH_W-1:0];
      a_pos_r <= !da[DEPTH_W] && (da != '0);
      b_pos_r <= !db[DEPTH_W] && (db != '0);
      orow_r  <= cmd.sel_b ? cur_r_r : cur_r_r - HB'(1);
      ocol_r  <= cur_c_r;
      olast_r <= cmd.sel_b && last_r;
      lo_r    <= '0;
    end
    if (cmd.sq1) ua2_r <= mul_p_r[SQ_W-1:0];
    if (cmd.sq2) begin
      ub2_r <= mul_p_r[SQ_W-1:0];
      q_r   <= Q_W'(ua2_r) + Q_W'(mul_p_r[SQ_W-1:0]) + Q_W'(4);
    end
    if (cmd.t1) t2_r <= mul_p_r[SQ_W-1:0];
    if (cmd.t2 || cmd.p2) plo_r <= mul_p_r;
    if (cmd.t3) begin
      if (cmd.bit_idx == '0) begin
        lo_r <= '0;
        case (cmd.mag_sel)
          MAG_X:   mx_r  <= lo_new;
          MAG_Y:   my_r  <= lo_new;
          default: mzn_r <= lo_new;
        endcase
      end else begin
        lo_r <= lo_new;
      end
    end
    if (cmd.p0) proj_neg_r <= pneg;
    if (cmd.p1) mz_r <= mul_p_r[MZ_W-1:0];
    if (cmd.p3) begin
      if (cmd.proj_y) vy_r <= vres;
      else vx_r <= vres;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pixel_row    <= POS_OUT_W'(orow_r);
      out_pixel_col    <= POS_OUT_W'(ocol_r);
      out_vertex_valid <= valid_r;
      out_vertex_x     <= valid_r ? vx_r : '0;
      out_vertex_y     <= valid_r ? vy_r : '0;
      out_vertex_z     <= valid_r ? VZ_W'(0) - VZ_W'(ctr_r) : '0;
      out_normal_x     <= a_pos_r ? NXY_W'(0) - NXY_W'(mx_r) : NXY_W'(mx_r);
      out_normal_y     <= b_pos_r ? NXY_W'(0) - NXY_W'(my_r) : NXY_W'(my_r);
      out_normal_z     <= mzn_r;
      out_frame_last   <= olast_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.has_a    = has_a_r;
  assign sts.has_b    = has_b_r;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

[rtl/depth_to_point_cloud_normals.sv]
// ----------------------------------------------------------------------------
// depth_to_point_cloud_normals
// raster depth pixels in, back-projected vertices with unit normals out
// ----------------------------------------------------------------------------
// usage
//   in_*  : one depth pixel per beat, raster order; in_frame_start marks
//           row 0 column 0. valid/ready handshake.
//   out_* : result beats, valid/ready handshake. a pixel of row r is
//           described while row r+1 streams in; on the last row its beat
//           follows right after the one for the row above, so a pixel gives
//           zero, one or two beats.
//   cfg_* : register writes, one per cycle, only while the block is idle.
// sequence
//   counters and line store access per pixel (one read port per store,
//   two reads of the previous row), then per result: the normal
//   magnitudes run a 15-step bit search on the one shared 32x22
//   multiplier, 3 magnitudes per result, then two projections. one
//   pixel at a time.
// reset
//   counters, left neighbor and handshakes clear; registers take their
//   defaults. line store entries hold garbage until the first frame fills
//   them; no clearing pass is run.
// stall
//   the finished beat sits in the output register; the next pixel is taken
//   meanwhile, and the sequencer waits only when it has a new beat to load.
// ----------------------------------------------------------------------------
module depth_to_point_cloud_normals
  import dtpcn_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // pixel input
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [DEPTH_W-1:0]      in_depth_mm,
  input  logic                    in_frame_start,
  // result output
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [POS_OUT_W-1:0]    out_pixel_row,
  output logic [POS_OUT_W-1:0]    out_pixel_col,
  output logic                    out_vertex_valid,
  output logic signed [VXY_W-1:0] out_vertex_x,
  output logic signed [VXY_W-1:0] out_vertex_y,
  output logic signed [VZ_W-1:0]  out_vertex_z,
  output logic signed [NXY_W-1:0] out_normal_x,
  output logic signed [NXY_W-1:0] out_normal_y,
  output logic [MAG_W-1:0]        out_normal_z,
  output logic                    out_frame_last,
  // register writes
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [FOCAL_W-1:0]      cfg_wdata
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  // register file, fields take the low bits of the write data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width    <= DIM_W'(512);
      cfg_r.frame_height   <= DIM_W'(424);
      cfg_r.min_depth      <= DEPTH_W'(0);
      cfg_r.max_depth      <= DEPTH_W'(65535);
      cfg_r.edge_threshold <= DEPTH_W'(20);
      cfg_r.center_x       <= CENTER_W'(16786182);
      cfg_r.center_y       <= CENTER_W'(13501327);
      cfg_r.inv_focal      <= FOCAL_W'(11749914);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:    cfg_r.frame_width    <= cfg_wdata[DIM_W-1:0];
        CFG_FRAME_HEIGHT:   cfg_r.frame_height   <= cfg_wdata[DIM_W-1:0];
        CFG_MIN_DEPTH:      cfg_r.min_depth      <= cfg_wdata[DEPTH_W-1:0];
        CFG_MAX_DEPTH:      cfg_r.max_depth      <= cfg_wdata[DEPTH_W-1:0];
        CFG_EDGE_THRESHOLD: cfg_r.edge_threshold <= cfg_wdata[DEPTH_W-1:0];
        CFG_CENTER_X:       cfg_r.center_x       <= cfg_wdata[CENTER_W-1:0];
        CFG_CENTER_Y:       cfg_r.center_y       <= cfg_wdata[CENTER_W-1:0];
        CFG_INV_FOCAL:      cfg_r.inv_focal      <= cfg_wdata;
        default:            ;
      endcase
    end
  end

  // sequencer
  dtpcn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // line stores, arithmetic and output register
  dtpcn_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .sts              (sts),
    .in_depth_mm      (in_depth_mm),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_row    (out_pixel_row),
    .out_pixel_col    (out_pixel_col),
    .out_vertex_valid (out_vertex_valid),
    .out_vertex_x     (out_vertex_x),
    .out_vertex_y     (out_vertex_y),
    .out_vertex_z     (out_vertex_z),
    .out_normal_x     (out_normal_x),
    .out_normal_y     (out_normal_y),
    .out_normal_z     (out_normal_z),
    .out_frame_last   (out_frame_last)
  );

endmodule

[tb/dtpcn_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpcn_checker
// watches the pixel, result and register ports of the depth to point cloud
// block, predicts every result beat and compares it with what comes out
// ----------------------------------------------------------------------------
module dtpcn_checker
  import dtpcn_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [DEPTH_W-1:0]      in_depth_mm,
  input  logic                    in_frame_start,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [POS_OUT_W-1:0]    out_pixel_row,
  input  logic [POS_OUT_W-1:0]    out_pixel_col,
  input  logic                    out_vertex_valid,
  input  logic signed [VXY_W-1:0] out_vertex_x,
  input  logic signed [VXY_W-1:0] out_vertex_y,
  input  logic signed [VZ_W-1:0]  out_vertex_z,
  input  logic signed [NXY_W-1:0] out_normal_x,
  input  logic signed [NXY_W-1:0] out_normal_y,
  input  logic [MAG_W-1:0]        out_normal_z,
  input  logic                    out_frame_last,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [FOCAL_W-1:0]      cfg_wdata,
  output int                      mismatches,
  output int                      pending
);

  typedef struct packed {
    logic [POS_OUT_W-1:0] row;
    logic [POS_OUT_W-1:0] col;
    logic                 vvalid;
    logic [VXY_W-1:0]     vx;
    logic [VXY_W-1:0]     vy;
    logic [VZ_W-1:0]      vz;
    logic [NXY_W-1:0]     nx;
    logic [NXY_W-1:0]     ny;
    logic [MAG_W-1:0]     nz;
    logic                 last;
  } point_t;

  cfg_t                 regs;
  logic [DEPTH_W-1:0]   line_prev  [512];
  logic [DEPTH_W-1:0]   line_older [512];
  logic [DEPTH_W-1:0]   left_nb;
  int                   row_ctr, col_ctr;
  point_t               point_q [$];

  // round(m * 2^14 / sqrt(q)), halves up, by bisection on squares
  function automatic logic [MAG_W-1:0] unit_mag(longint unsigned m, longint unsigned q);
    longint unsigned lo, hi, mid, t;
    logic [127:0] rhs, lhs;
    lo = 0;
    hi = 1 << NFRAC;
    rhs = 128'(2 * m * (1 << NFRAC)) * 128'(2 * m * (1 << NFRAC));
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      lhs = 128'(t) * 128'(t) * 128'(q);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[MAG_W-1:0];
  endfunction

  function automatic logic [VXY_W-1:0] backproject(longint unsigned z, longint unsigned pos,
                                                   longint unsigned c, bit negate);
    longint unsigned p16, mag;
    logic [127:0] prod, r, lim;
    bit neg;
    p16 = pos << 16;
    if (p16 >= c) begin
      mag = p16 - c;
      neg = 0;
    end else begin
      mag = c - p16;
      neg = 1;
    end
    neg = neg ^ negate;
    prod = 128'(mag) * 128'(z) * 128'(regs.inv_focal);
    r = (prod + (128'(1) << 43)) >> 44;
    lim = neg ? (128'(1) << 27) : ((128'(1) << 27) - 1);
    if (r > lim) r = lim;
    if (neg) r = -r;
    return r[VXY_W-1:0];
  endfunction

  function automatic longint unsigned edge_gate(longint unsigned ctr, longint unsigned nb);
    longint unsigned d;
    d = (ctr > nb) ? ctr - nb : nb - ctr;
    return (d > regs.edge_threshold) ? 0 : nb;
  endfunction

  function automatic point_t make_point(int r, int c, longint unsigned ctr, bit inner,
                                        longint unsigned above, longint unsigned below,
                                        longint unsigned prior, longint unsigned after,
                                        bit last);
    point_t p;
    longint da, db;
    longint unsigned ua, ub, q;
    logic [MAG_W-1:0] mx, my;
    bit ok;
    ok = (ctr != 0) && (ctr >= regs.min_depth) && (ctr <= regs.max_depth);
    if (!inner) begin
      above = 0; below = 0; prior = 0; after = 0;
    end
    above = edge_gate(ctr, above);
    below = edge_gate(ctr, below);
    prior = edge_gate(ctr, prior);
    after = edge_gate(ctr, after);
    da = longint'(below) - longint'(above);
    db = longint'(after) - longint'(prior);
    ua = (da < 0) ? -da : da;
    ub = (db < 0) ? -db : db;
    q = ua * ua + ub * ub + 4;
    mx = unit_mag(ua, q);
    my = unit_mag(ub, q);
    p.row = r[POS_OUT_W-1:0];
    p.col = c[POS_OUT_W-1:0];
    p.vvalid = ok;
    p.vx = ok ? backproject(ctr, c, regs.center_x, 1'b0) : '0;
    p.vy = ok ? backproject(ctr, r, regs.center_y, 1'b1) : '0;
    p.vz = ok ? VZ_W'(-ctr) : '0;
    p.nx = (da > 0) ? -NXY_W'(mx) : NXY_W'(mx);
    p.ny = (db > 0) ? -NXY_W'(my) : NXY_W'(my);
    p.nz = unit_mag(2, q);
    p.last = last;
    return p;
  endfunction

  function automatic int dim_clamp(int v);
    if (v < 1) return 1;
    if (v > 512) return 512;
    return v;
  endfunction

  // append one predicted beat at the tail
  task automatic queue_point(point_t p);
    point_q = {point_q, p};
  endtask

  task automatic take_pixel(logic [DEPTH_W-1:0] depth, logic fs);
    int w, h, c;
    bit inner;
    w = dim_clamp(regs.frame_width);
    h = dim_clamp(regs.frame_height);
    if (fs) begin
      row_ctr = 0;
      col_ctr = 0;
    end
    // counters past a shrunk size wrap
    if (col_ctr >= w) begin
      col_ctr = 0;
      row_ctr++;
    end
    if (row_ctr >= h) row_ctr = 0;
    c = col_ctr;
    if (row_ctr >= 1) begin
      inner = (row_ctr - 1 > 0) && (c > 0) && (c + 1 < w);
      queue_point(make_point(row_ctr - 1, c, line_prev[c], inner, line_older[c],
                             depth, left_nb, inner ? line_prev[c+1] : 16'd0, 1'b0));
    end
    left_nb = line_prev[c];
    line_older[c] = line_prev[c];
    line_prev[c] = depth;
    // last row is described at once
    if (row_ctr + 1 == h)
      queue_point(make_point(row_ctr, c, depth, 1'b0, 0, 0, 0, 0, c + 1 == w));
    col_ctr++;
    if (col_ctr >= w) begin
      col_ctr = 0;
      row_ctr++;
      if (row_ctr >= h) row_ctr = 0;
    end
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
    for (int i = 0; i < 512; i++) begin
      line_prev[i] = '0;
      line_older[i] = '0;
    end
  end

  always @(posedge clk) begin
    point_t got, want;
    if (!rst_n) begin
      regs.frame_width    = 10'd512;
      regs.frame_height   = 10'd424;
      regs.min_depth      = 16'd0;
      regs.max_depth      = 16'd65535;
      regs.edge_threshold = 16'd20;
      regs.center_x       = 26'd16786182;
      regs.center_y       = 26'd13501327;
      regs.inv_focal      = 32'd11749914;
      left_nb = '0;
      row_ctr = 0;
      col_ctr = 0;
      point_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:    regs.frame_width    = cfg_wdata[DIM_W-1:0];
          CFG_FRAME_HEIGHT:   regs.frame_height   = cfg_wdata[DIM_W-1:0];
          CFG_MIN_DEPTH:      regs.min_depth      = cfg_wdata[DEPTH_W-1:0];
          CFG_MAX_DEPTH:      regs.max_depth      = cfg_wdata[DEPTH_W-1:0];
          CFG_EDGE_THRESHOLD: regs.edge_threshold = cfg_wdata[DEPTH_W-1:0];
          CFG_CENTER_X:       regs.center_x       = cfg_wdata[CENTER_W-1:0];
          CFG_CENTER_Y:       regs.center_y       = cfg_wdata[CENTER_W-1:0];
          CFG_INV_FOCAL:      regs.inv_focal      = cfg_wdata;
          default: ;
        endcase
      end
      // compare first: a beat leaving now belongs to an older pixel
      if (out_valid && out_ready) begin
        got = '{out_pixel_row, out_pixel_col, out_vertex_valid, out_vertex_x, out_vertex_y,
                out_vertex_z, out_normal_x, out_normal_y, out_normal_z, out_frame_last};
        if (point_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result beat with nothing expected: row %0d col %0d", got.row, got.col);
        end else begin
          want = point_q.pop_front();
          if (got.row != want.row || got.col != want.col || got.vvalid != want.vvalid ||
              got.vx != want.vx || got.vy != want.vy || got.vz != want.vz ||
              got.nx != want.nx || got.ny != want.ny || got.nz != want.nz ||
              got.last != want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp: r%0d c%0d v%0d x%0d y%0d z%0d n %0d %0d %0d l%0d",
                       want.row, want.col, want.vvalid, $signed(want.vx), $signed(want.vy),
                       $signed(want.vz), $signed(want.nx), $signed(want.ny), want.nz,
                       want.last);
              $display("         got: r%0d c%0d v%0d x%0d y%0d z%0d n %0d %0d %0d l%0d",
                       got.row, got.col, got.vvalid, $signed(got.vx), $signed(got.vy),
                       $signed(got.vz), $signed(got.nx), $signed(got.ny), got.nz, got.last);
            end
          end
        end
      end
      if (in_valid && in_ready) take_pixel(in_depth_mm, in_frame_start);
    end
    pending = point_q.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives raster depth frames through the point cloud block under changing
// frame sizes, depth windows, edge thresholds and camera settings, with
// random idling on both sides; the checker judges every result beat
// ----------------------------------------------------------------------------
module tb_top;
  import dtpcn_pkg::*;

  localparam int LIMIT       = 1000000;  // cycles before the run is abandoned
  localparam int DRAIN       = 400;      // wait after the checker queue empties
  localparam int RAND_ITEMS  = 550;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [DEPTH_W-1:0]      in_depth_mm;
  logic                    in_frame_start;
  logic                    out_valid;
  logic                    out_ready;
  logic [POS_OUT_W-1:0]    out_pixel_row;
  logic [POS_OUT_W-1:0]    out_pixel_col;
  logic                    out_vertex_valid;
  logic signed [VXY_W-1:0] out_vertex_x;
  logic signed [VXY_W-1:0] out_vertex_y;
  logic signed [VZ_W-1:0]  out_vertex_z;
  logic signed [NXY_W-1:0] out_normal_x;
  logic signed [NXY_W-1:0] out_normal_y;
  logic [MAG_W-1:0]        out_normal_z;
  logic                    out_frame_last;
  logic                    cfg_wr_en;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [FOCAL_W-1:0]      cfg_wdata;

  int mismatches, pending;
  int cycles;
  int since_fs;       // beats since the last frame start
  int cur_w;          // width in force, after clamping
  int rand_sent;
  bit calm;           // no idling on either side during this phase
  bit hold_req;       // ask the receiver for one long hold-off

  depth_to_point_cloud_normals uut (.*);

  dtpcn_checker chk (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic int dim_eff(int v);
    if (v < 1) return 1;
    if (v > 512) return 512;
    return v;
  endfunction

  // one register write per cycle, enable held across back-to-back writes
  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // wait for the block to drain before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic setup(int w, int h, int mn, int mx, int thr,
                       logic [31:0] cx, logic [31:0] cy, logic [31:0] inv);
    wait_idle();
    reg_write(CFG_FRAME_WIDTH, w);
    reg_write(CFG_FRAME_HEIGHT, h);
    reg_write(CFG_MIN_DEPTH, mn);
    reg_write(CFG_MAX_DEPTH, mx);
    reg_write(CFG_EDGE_THRESHOLD, thr);
    reg_write(CFG_CENTER_X, cx);
    reg_write(CFG_CENTER_Y, cy);
    reg_write(CFG_INV_FOCAL, inv);
    cfg_wr_en <= 1'b0;
  endtask

  // one pixel beat; called at a rising edge
  task automatic send_pixel(logic [DEPTH_W-1:0] d, logic fs);
    int gap;
    bit acc;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_depth_mm    <= d;
    in_frame_start <= fs;
    do begin
      @(negedge clk);
      acc = in_ready;
      @(posedge clk);
    end while (!acc);
    since_fs = fs ? 1 : since_fs + 1;
  endtask

  // mostly smooth surfaces around a base, with holes and extremes mixed in
  function automatic logic [DEPTH_W-1:0] pick_depth(int base);
    int v;
    case ($urandom_range(0, 11))
      0: v = 0;
      1: v = 65535;
      2: v = $urandom_range(0, 65535);
      default: v = base + $urandom_range(0, 60) - 30;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[DEPTH_W-1:0];
  endfunction

  // one random phase: fresh settings, then a stream of frames
  task automatic random_phase(int phase_no);
    int w, h, mn, mx, thr, n, we, he, idx, base, old_w;
    logic [31:0] cx, cy, inv;
    bit need_fs, fs;
    case ($urandom_range(0, 19))
      0: w = 0;
      1: w = 1;
      2: w = 2;
      3: w = 1000;
      4: w = 512;
      default: w = $urandom_range(3, 10);
    endcase
    case ($urandom_range(0, 15))
      0: h = 0;
      1: h = 1;
      2: h = 512;
      default: h = $urandom_range(2, 6);
    endcase
    // keep the slow corners short
    if (dim_eff(w) > 16) h = 1;
    if (dim_eff(h) > 16) w = $urandom_range(1, 2);
    we = dim_eff(w);
    he = dim_eff(h);
    case ($urandom_range(0, 5))
      0: begin mn = 0; mx = 65535; end
      1: begin mn = $urandom_range(30000, 65535); mx = $urandom_range(0, 29999); end
      2: begin mn = $urandom_range(0, 65535); mx = mn; end
      default: begin mn = $urandom_range(0, 2000); mx = $urandom_range(30000, 65535); end
    endcase
    case ($urandom_range(0, 5))
      0: thr = 0;
      1: thr = 65535;
      default: thr = $urandom_range(0, 100);
    endcase
    case ($urandom_range(0, 4))
      0: cx = 0;
      1: cx = 32'h03FF_FFFF;
      default: cx = $urandom_range(0, 32'h03FF_FFFF);
    endcase
    case ($urandom_range(0, 4))
      0: cy = 0;
      1: cy = 32'h03FF_FFFF;
      default: cy = $urandom_range(0, 32'h03FF_FFFF);
    endcase
    case ($urandom_range(0, 5))
      0: inv = 0;
      1: inv = 32'hFFFF_FFFF;
      2: inv = 32'd11749914;
      default: inv = $urandom;
    endcase
    if (we > 16) n = 20;
    else if (he > 16) n = 30;
    else begin
      n = 2 * we * he + $urandom_range(0, 8);
      if (n > 60) n = 60;
      if (n < 10) n = 10;
    end
    old_w = cur_w;
    setup(w, h, mn, mx, thr, cx, cy, inv);
    cur_w = we;
    calm = ($urandom_range(0, 4) == 0);
    if (phase_no == 3) begin
      // receiver goes quiet while pixels keep coming
      calm = 1'b1;
      hold_req = 1'b1;
    end
    // line stores hold every column if two full rows came since the last
    // frame start; only then may the stream go on without one
    need_fs = !(we <= old_w && since_fs >= 2 * old_w && $urandom_range(0, 1));
    idx = 0;
    base = $urandom_range(1, 65535);
    for (int i = 0; i < n; i++) begin
      fs = (i == 0 && need_fs) || (i > 0 && idx == 0 && $urandom_range(0, 9) < 7) ||
           ($urandom_range(0, 49) == 0);
      if (fs) begin
        idx = 0;
        if ($urandom_range(0, 1)) base = $urandom_range(1, 65535);
      end
      send_pixel(pick_depth(base), fs);
      idx++;
      if (idx == we * he) idx = 0;
      rand_sent++;
    end
  endtask

  // receiver: random stalls per beat, plus one long hold-off on request
  initial begin
    int stall;
    bit acc;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
      end else if (!calm) begin
        stall = $urandom_range(0, 17);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        acc = out_valid;
        @(posedge clk);
      end while (!acc);
    end
  end

  // stimulus and verdict
  initial begin
    logic [DEPTH_W-1:0] frame_a [9];
    logic [DEPTH_W-1:0] frame_b [9];
    int ph;
    // center of the 3x3 frame: three neighbours inside the threshold, the
    // right one beyond it, a hole and a tiny depth on the bottom row
    frame_a = '{16'd1000, 16'd1010, 16'd65535,
                16'd990,  16'd1000, 16'd1030,
                16'd0,    16'd1015, 16'd1};
    frame_b = '{16'd65535, 16'd0, 16'd65535,
                16'd0, 16'd65535, 16'd0,
                16'd65535, 16'd0, 16'd65535};
    cycles = 0;
    since_fs = 0;
    cur_w = 512;
    rand_sent = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_depth_mm = '0;
    in_frame_start = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: small frame, default camera
    setup(3, 3, 0, 65535, 20, 32'd16786182, 32'd13501327, 32'd11749914);
    cur_w = 3;
    for (int i = 0; i < 9; i++) send_pixel(frame_a[i], i == 0);
    // next frame follows by wrap, no frame start
    for (int i = 0; i < 9; i++) send_pixel(frame_b[i], 1'b0);

    // random phases
    ph = 0;
    while (rand_sent < RAND_ITEMS) begin
      random_phase(ph);
      ph++;
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
